### rtl/pst_pkg.sv
`default_nettype none
package pst_pkg;

    localparam int W_PROTO = 8;
    localparam int W_FLAGS = 8;
    localparam int W_ADDR  = 32;
    localparam int W_PORT  = 16;
    localparam int W_TIME  = 48;
    localparam int W_SCORE = 16;
    localparam int W_WIN   = 20;
    localparam int W_WGT   = 8;
    localparam int W_STAT  = 3;

    // Configuration port
    localparam int W_CFG_IDX  = 3;
    localparam int W_CFG_DATA = 20;

    localparam logic [W_CFG_IDX-1:0] CFG_THRESHOLD  = 3'd0;
    localparam logic [W_CFG_IDX-1:0] CFG_WINDOW     = 3'd1;
    localparam logic [W_CFG_IDX-1:0] CFG_WGT_SPEC   = 3'd2;
    localparam logic [W_CFG_IDX-1:0] CFG_WGT_WK     = 3'd3;
    localparam logic [W_CFG_IDX-1:0] CFG_WGT_OTHER  = 3'd4;
    localparam logic [W_CFG_IDX-1:0] CFG_WK_LIMIT   = 3'd5;

    localparam logic [W_SCORE-1:0] RST_THRESHOLD = 16'd21;
    localparam logic [W_WIN-1:0]   RST_WINDOW    = 20'd300000;
    localparam logic [W_WGT-1:0]   RST_WGT_SPEC  = 8'd10;
    localparam logic [W_WGT-1:0]   RST_WGT_WK    = 8'd3;
    localparam logic [W_WGT-1:0]   RST_WGT_OTHER = 8'd1;
    localparam logic [W_PORT-1:0]  RST_WK_LIMIT  = 16'd1024;

    localparam logic [W_PROTO-1:0] PROTO_TCP = 8'd6;
    localparam int FLAG_FIN = 0;
    localparam int FLAG_SYN = 1;
    localparam int FLAG_ACK = 4;

    localparam logic [W_PORT-1:0] PORT_SPEC_A = 16'd11;
    localparam logic [W_PORT-1:0] PORT_SPEC_B = 16'd12;
    localparam logic [W_PORT-1:0] PORT_SPEC_C = 16'd13;
    localparam logic [W_PORT-1:0] PORT_SPEC_D = 16'd2000;

    localparam logic [W_SCORE-1:0] SCORE_MAX = 16'hFFFF;

    typedef enum logic [W_STAT-1:0] {
        ST_IGNORED = 3'd0,
        ST_NEW     = 3'd1,
        ST_SCORED  = 3'd2,
        ST_SCAN    = 3'd3,
        ST_RESTART = 3'd4,
        ST_FULL    = 3'd5
    } t_status;

    // One way of a bucket row
    typedef struct packed {
        logic               valid;
        logic [W_ADDR-1:0]  addr;
        logic [W_SCORE-1:0] score;
        logic [W_TIME-1:0]  start;
    } t_entry;

    // Decision of the update logic
    typedef struct packed {
        logic               wr_en;
        t_status            status;
        logic [W_SCORE-1:0] score;
        logic [W_TIME-1:0]  start;
    } t_upd;

endpackage
`default_nettype wire

### rtl/pst_ifs.sv
`default_nettype none
interface pst_in_if;
    logic                        valid;
    logic                        ready;
    logic [pst_pkg::W_PROTO-1:0] ip_protocol;
    logic [pst_pkg::W_FLAGS-1:0] tcp_flag_bits;
    logic [pst_pkg::W_ADDR-1:0]  source_address;
    logic [pst_pkg::W_PORT-1:0]  target_port;
    logic [pst_pkg::W_TIME-1:0]  arrival_us;

    modport source (
        output valid, ip_protocol, tcp_flag_bits, source_address, target_port, arrival_us,
        input  ready
    );
    modport sink (
        input  valid, ip_protocol, tcp_flag_bits, source_address, target_port, arrival_us,
        output ready
    );
endinterface

interface pst_out_if;
    logic                        valid;
    logic                        ready;
    logic [pst_pkg::W_STAT-1:0]  status;
    logic [pst_pkg::W_ADDR-1:0]  reported_address;
    logic [pst_pkg::W_SCORE-1:0] reported_score;
    logic [pst_pkg::W_TIME-1:0]  window_start_us;

    modport source (
        output valid, status, reported_address, reported_score, window_start_us,
        input  ready
    );
    modport sink (
        input  valid, status, reported_address, reported_score, window_start_us,
        output ready
    );
endinterface
`default_nettype wire

### rtl/port_scan_heat_tracker.sv
`default_nettype none
// Port scan heat tracker. Each item on i_pkt is one packet header; each accepted
// item gives exactly one item on o_rpt, in order. Only TCP packets whose flag
// byte is a plain SYN (SYN set, ACK and FIN clear) are scored; everything else
// reports status ignored. The source address is XOR-folded in FOLD_BITS-wide
// slices into one of BUCKETS buckets (BUCKETS a power of two), each holding
// WAYS entries of address, heat score and window start. A known source inside
// its window adds the port weight (saturating at 65535) and reports a scan once
// the score reaches the threshold, which also zeroes the score and restarts the
// window; a source past its window restarts with this packet's weight; a new
// source takes the lowest free way; a full bucket leaves the table alone.
// The whole bucket row lives in one memory word. For each item the accept edge
// issues the row read, and the edge that leaves the look state writes the
// updated row back and loads the output register. The block takes no new item
// until the write is done, so a read never sees a stale row. A result that is
// not taken holds the update stage until o_rpt is free. After reset the block
// clears the table, one row per cycle, and holds i_pkt.ready low meanwhile;
// configuration writes are taken at any time and must be issued while idle.
module port_scan_heat_tracker #(
    parameter int BUCKETS   = 256,
    parameter int FOLD_BITS = 8,
    parameter int WAYS      = 4
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    pst_in_if.sink                           i_pkt,
    pst_out_if.source                        o_rpt,
    input  wire                              i_cfg_we,
    input  wire  [pst_pkg::W_CFG_IDX-1:0]    i_cfg_idx,
    input  wire  [pst_pkg::W_CFG_DATA-1:0]   i_cfg_data
);
    import pst_pkg::*;

    localparam int IDX_W = $clog2(BUCKETS);
    localparam int FOLDS = (W_ADDR + FOLD_BITS - 1) / FOLD_BITS;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_LOOK  = 3'b100
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [W_SCORE-1:0] r_threshold;
    logic [W_WIN-1:0]   r_window;
    logic [W_WGT-1:0]   r_wgt_spec;
    logic [W_WGT-1:0]   r_wgt_wk;
    logic [W_WGT-1:0]   r_wgt_other;
    logic [W_PORT-1:0]  r_wk_limit;

    // Captured item
    logic [IDX_W-1:0]   r_idx;
    logic [W_ADDR-1:0]  r_addr;
    logic [W_TIME-1:0]  r_now;
    logic [W_WGT-1:0]   r_weight;
    logic               r_scored;

    // Clear sweep
    logic [IDX_W-1:0]   r_clr_cnt;

    // Output register
    logic               r_out_valid;
    t_status            r_status;
    logic [W_ADDR-1:0]  r_out_addr;
    logic [W_SCORE-1:0] r_out_score;
    logic [W_TIME-1:0]  r_out_start;

    logic               in_acc;
    logic               can_load;
    logic [IDX_W-1:0]   hash_idx;
    logic [W_WGT-1:0]   weight;
    logic               scored;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    t_entry [WAYS-1:0]  mem_wdata;
    t_entry [WAYS-1:0]  mem_rdata;
    t_entry [WAYS-1:0]  upd_row;
    t_upd               upd;

    function automatic logic [IDX_W-1:0] fold_hash(input logic [W_ADDR-1:0] a);
        logic [W_ADDR-1:0] h;
        h = '0;
        for (int k = 0; k < FOLDS; k++) begin
            h ^= a >> (k * FOLD_BITS);
        end
        return h[IDX_W-1:0];
    endfunction

    assign i_pkt.ready = (r_state == S_IDLE);
    assign in_acc      = i_pkt.valid && i_pkt.ready;
    assign can_load    = (r_state == S_LOOK) && (!r_out_valid || o_rpt.ready);
    assign hash_idx    = fold_hash(i_pkt.source_address);

    // Classify and weigh at the accept edge
    assign scored = (i_pkt.ip_protocol == PROTO_TCP) && i_pkt.tcp_flag_bits[FLAG_SYN]
                    && !i_pkt.tcp_flag_bits[FLAG_ACK] && !i_pkt.tcp_flag_bits[FLAG_FIN];

    always_comb begin
        if (i_pkt.target_port == PORT_SPEC_A || i_pkt.target_port == PORT_SPEC_B ||
            i_pkt.target_port == PORT_SPEC_C || i_pkt.target_port == PORT_SPEC_D) begin
            weight = r_wgt_spec;
        end else if (i_pkt.target_port < r_wk_limit) begin
            weight = r_wgt_wk;
        end else begin
            weight = r_wgt_other;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= RST_THRESHOLD;
            r_window    <= RST_WINDOW;
            r_wgt_spec  <= RST_WGT_SPEC;
            r_wgt_wk    <= RST_WGT_WK;
            r_wgt_other <= RST_WGT_OTHER;
            r_wk_limit  <= RST_WK_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD: r_threshold <= i_cfg_data[W_SCORE-1:0];
                CFG_WINDOW:    r_window    <= i_cfg_data[W_WIN-1:0];
                CFG_WGT_SPEC:  r_wgt_spec  <= i_cfg_data[W_WGT-1:0];
                CFG_WGT_WK:    r_wgt_wk    <= i_cfg_data[W_WGT-1:0];
                CFG_WGT_OTHER: r_wgt_other <= i_cfg_data[W_WGT-1:0];
                CFG_WK_LIMIT:  r_wk_limit  <= i_cfg_data[W_PORT-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: clear sweep, then accept / read / update
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_cnt == IDX_W'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (can_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + IDX_W'(1);
            end
        end
    end

    // Hold the item while its row is read and updated
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_idx    <= hash_idx;
            r_addr   <= i_pkt.source_address;
            r_now    <= i_pkt.arrival_us;
            r_weight <= weight;
            r_scored <= scored;
        end
    end

    pst_table #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (in_acc),
        .i_raddr (hash_idx),
        .o_rdata (mem_rdata)
    );

    pst_update #(
        .WAYS (WAYS)
    ) u_update (
        .i_row       (mem_rdata),
        .i_scored    (r_scored),
        .i_addr      (r_addr),
        .i_now       (r_now),
        .i_weight    (r_weight),
        .i_threshold (r_threshold),
        .i_window    (r_window),
        .o_row       (upd_row),
        .o_upd       (upd)
    );

    // Write port: zero rows during the sweep, else the updated row
    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_cnt;
            mem_wdata = '0;
        end else begin
            mem_we    = can_load && upd.wr_en;
            mem_waddr = r_idx;
            mem_wdata = upd_row;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rpt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load) begin
            r_status    <= upd.status;
            r_out_addr  <= r_addr;
            r_out_score <= upd.score;
            r_out_start <= upd.start;
        end
    end

    assign o_rpt.valid            = r_out_valid;
    assign o_rpt.status           = r_status;
    assign o_rpt.reported_address = r_out_addr;
    assign o_rpt.reported_score   = r_out_score;
    assign o_rpt.window_start_us  = r_out_start;

endmodule
`default_nettype wire

### rtl/pst_table.sv
`default_nettype none
module pst_table #(
    parameter int BUCKETS = 256,
    parameter int WAYS    = 4
) (
    input  wire                                   i_clk,
    input  wire                                   i_we,
    input  wire  [$clog2(BUCKETS)-1:0]            i_waddr,
    input  pst_pkg::t_entry [WAYS-1:0]            i_wdata,
    input  wire                                   i_re,
    input  wire  [$clog2(BUCKETS)-1:0]            i_raddr,
    output pst_pkg::t_entry [WAYS-1:0]            o_rdata
);
    import pst_pkg::*;

    t_entry [WAYS-1:0] r_mem [BUCKETS];
    t_entry [WAYS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### rtl/pst_update.sv
`default_nettype none
module pst_update #(
    parameter int WAYS = 4
) (
    input  pst_pkg::t_entry [WAYS-1:0]       i_row,
    input  wire                              i_scored,
    input  wire  [pst_pkg::W_ADDR-1:0]       i_addr,
    input  wire  [pst_pkg::W_TIME-1:0]       i_now,
    input  wire  [pst_pkg::W_WGT-1:0]        i_weight,
    input  wire  [pst_pkg::W_SCORE-1:0]      i_threshold,
    input  wire  [pst_pkg::W_WIN-1:0]        i_window,
    output pst_pkg::t_entry [WAYS-1:0]       o_row,
    output pst_pkg::t_upd                    o_upd
);
    import pst_pkg::*;

    logic [WAYS-1:0]    hit_sel;
    logic [WAYS-1:0]    free_sel;
    logic [WAYS-1:0]    way_within;
    logic [W_SCORE-1:0] way_sat [WAYS];
    logic               any_hit;
    logic               any_free;
    logic               sel_within;
    logic [W_SCORE-1:0] sel_sat;
    logic [W_TIME-1:0]  sel_start;
    logic [W_SCORE-1:0] wgt_ext;

    assign wgt_ext = {{(W_SCORE-W_WGT){1'b0}}, i_weight};

    // Per-way window check and saturating sum
    always_comb begin
        logic [W_SCORE:0] sum;
        logic [W_TIME:0]  limit;
        for (int k = 0; k < WAYS; k++) begin
            sum   = {1'b0, i_row[k].score} + {1'b0, wgt_ext};
            way_sat[k] = sum[W_SCORE] ? SCORE_MAX : sum[W_SCORE-1:0];
            limit = {1'b0, i_row[k].start} + {{(W_TIME+1-W_WIN){1'b0}}, i_window};
            // an earlier timestamp counts as zero elapsed and is always within
            way_within[k] = ({1'b0, i_now} <= limit);
        end
    end

    // Lowest matching way, lowest free way
    always_comb begin
        logic hit_found;
        logic free_found;
        hit_sel    = '0;
        free_sel   = '0;
        hit_found  = 1'b0;
        free_found = 1'b0;
        for (int k = 0; k < WAYS; k++) begin
            if (i_row[k].valid) begin
                if (!hit_found && i_row[k].addr == i_addr) begin
                    hit_sel[k] = 1'b1;
                    hit_found  = 1'b1;
                end
            end else if (!free_found) begin
                free_sel[k] = 1'b1;
                free_found  = 1'b1;
            end
        end
    end

    assign any_hit  = |hit_sel;
    assign any_free = |free_sel;

    always_comb begin
        sel_within = 1'b0;
        sel_sat    = '0;
        sel_start  = '0;
        for (int k = 0; k < WAYS; k++) begin
            if (hit_sel[k]) begin
                sel_within = way_within[k];
                sel_sat    = way_sat[k];
                sel_start  = i_row[k].start;
            end
        end
    end

    always_comb begin
        o_row        = i_row;
        o_upd.wr_en  = 1'b0;
        o_upd.status = ST_IGNORED;
        o_upd.score  = '0;
        o_upd.start  = '0;
        if (i_scored) begin
            if (any_hit) begin
                o_upd.wr_en = 1'b1;
                if (sel_within) begin
                    o_upd.score = sel_sat;
                    o_upd.start = sel_start;
                    if (sel_sat >= i_threshold) begin
                        o_upd.status = ST_SCAN;
                    end else begin
                        o_upd.status = ST_SCORED;
                    end
                end else begin
                    o_upd.status = ST_RESTART;
                    o_upd.score  = wgt_ext;
                    o_upd.start  = i_now;
                end
                for (int k = 0; k < WAYS; k++) begin
                    if (hit_sel[k]) begin
                        if (!sel_within) begin
                            o_row[k].score = wgt_ext;
                            o_row[k].start = i_now;
                        end else if (sel_sat >= i_threshold) begin
                            o_row[k].score = '0;
                            o_row[k].start = i_now;
                        end else begin
                            o_row[k].score = sel_sat;
                        end
                    end
                end
            end else if (any_free) begin
                o_upd.wr_en  = 1'b1;
                o_upd.status = ST_NEW;
                o_upd.score  = wgt_ext;
                o_upd.start  = i_now;
                for (int k = 0; k < WAYS; k++) begin
                    if (free_sel[k]) begin
                        o_row[k].valid = 1'b1;
                        o_row[k].addr  = i_addr;
                        o_row[k].score = wgt_ext;
                        o_row[k].start = i_now;
                    end
                end
            end else begin
                o_upd.status = ST_FULL;
            end
        end
    end

endmodule
`default_nettype wire

### tb/sv/heat_report_checker.sv
`timescale 1ns / 1ps

module heat_report_checker import pst_pkg::*; #(
    parameter int BUCKETS   = 256,
    parameter int FOLD_BITS = 8,
    parameter int WAYS      = 4
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    pst_in_if                     i_pkt_mon,
    pst_out_if                    i_rpt_mon,
    input  wire                   i_cfg_we,
    input  wire  [W_CFG_IDX-1:0]  i_cfg_idx,
    input  wire  [W_CFG_DATA-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int DEPTH = BUCKETS * WAYS;

    typedef struct packed {
        t_status            status;
        logic [W_ADDR-1:0]  addr;
        logic [W_SCORE-1:0] score;
        logic [W_TIME-1:0]  start;
    } t_heat_report;

    // Mirror of the source table
    logic               slot_valid [DEPTH];
    logic [W_ADDR-1:0]  slot_addr  [DEPTH];
    logic [W_SCORE-1:0] slot_score [DEPTH];
    logic [W_TIME-1:0]  slot_start [DEPTH];

    logic [W_SCORE-1:0] score_threshold;
    logic [W_WIN-1:0]   window_us;
    logic [W_WGT-1:0]   wgt_special;
    logic [W_WGT-1:0]   wgt_well_known;
    logic [W_WGT-1:0]   wgt_other;
    logic [W_PORT-1:0]  well_known_limit;

    t_heat_report reports_due [$];

    // Score one header against the mirrored table and return its report.
    function automatic t_heat_report score_packet(
        input logic [W_PROTO-1:0] proto,
        input logic [W_FLAGS-1:0] flags,
        input logic [W_ADDR-1:0]  addr,
        input logic [W_PORT-1:0]  port,
        input logic [W_TIME-1:0]  now
    );
        t_heat_report       r;
        logic [W_ADDR-1:0]  fold;
        logic [W_ADDR-1:0]  rest;
        logic [W_WGT-1:0]   wgt;
        logic [W_SCORE:0]   sum;
        logic [W_TIME-1:0]  elapsed;
        int                 base;
        int                 hit;
        int                 spare;
        int                 slot;

        r.status = ST_IGNORED;
        r.addr   = addr;
        r.score  = '0;
        r.start  = '0;
        if (proto != PROTO_TCP || !flags[FLAG_SYN] || flags[FLAG_ACK] || flags[FLAG_FIN])
            return r;

        fold = '0;
        rest = addr;
        do begin
            fold ^= rest;
            rest = rest >> FOLD_BITS;
        end while (rest != '0);
        base = int'(fold & (BUCKETS - 1)) * WAYS;

        if (port == PORT_SPEC_A || port == PORT_SPEC_B || port == PORT_SPEC_C ||
            port == PORT_SPEC_D) begin
            wgt = wgt_special;
        end else if (port < well_known_limit) begin
            wgt = wgt_well_known;
        end else begin
            wgt = wgt_other;
        end

        hit   = -1;
        spare = -1;
        for (int k = 0; k < WAYS; k++) begin
            if (slot_valid[base + k]) begin
                if (hit < 0 && slot_addr[base + k] == addr)
                    hit = k;
            end else if (spare < 0) begin
                spare = k;
            end
        end

        if (hit >= 0) begin
            slot    = base + hit;
            elapsed = (now >= slot_start[slot]) ? now - slot_start[slot] : '0;
            if (elapsed <= W_TIME'(window_us)) begin
                sum = {1'b0, slot_score[slot]} + (W_SCORE+1)'(wgt);
                if (sum > (W_SCORE+1)'(SCORE_MAX))
                    sum = (W_SCORE+1)'(SCORE_MAX);
                r.score = sum[W_SCORE-1:0];
                r.start = slot_start[slot];
                if (sum >= (W_SCORE+1)'(score_threshold)) begin
                    r.status         = ST_SCAN;
                    slot_score[slot] = '0;
                    slot_start[slot] = now;
                end else begin
                    r.status         = ST_SCORED;
                    slot_score[slot] = sum[W_SCORE-1:0];
                end
            end else begin
                r.status         = ST_RESTART;
                r.score          = W_SCORE'(wgt);
                r.start          = now;
                slot_score[slot] = W_SCORE'(wgt);
                slot_start[slot] = now;
            end
        end else if (spare >= 0) begin
            slot             = base + spare;
            slot_valid[slot] = 1'b1;
            slot_addr[slot]  = addr;
            slot_score[slot] = W_SCORE'(wgt);
            slot_start[slot] = now;
            r.status         = ST_NEW;
            r.score          = W_SCORE'(wgt);
            r.start          = now;
        end else begin
            r.status = ST_FULL;
        end
        return r;
    endfunction

    task automatic check_field(
        input string             field,
        input logic [W_TIME-1:0] want,
        input logic [W_TIME-1:0] got
    );
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_heat_report want;

        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                slot_valid[i] = 1'b0;
                slot_addr[i]  = '0;
                slot_score[i] = '0;
                slot_start[i] = '0;
            end
            score_threshold  = RST_THRESHOLD;
            window_us        = RST_WINDOW;
            wgt_special      = RST_WGT_SPEC;
            wgt_well_known   = RST_WGT_WK;
            wgt_other        = RST_WGT_OTHER;
            well_known_limit = RST_WK_LIMIT;
            reports_due.delete();
            o_fail_count     = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_THRESHOLD: score_threshold  = i_cfg_data[W_SCORE-1:0];
                    CFG_WINDOW:    window_us        = i_cfg_data[W_WIN-1:0];
                    CFG_WGT_SPEC:  wgt_special      = i_cfg_data[W_WGT-1:0];
                    CFG_WGT_WK:    wgt_well_known   = i_cfg_data[W_WGT-1:0];
                    CFG_WGT_OTHER: wgt_other        = i_cfg_data[W_WGT-1:0];
                    CFG_WK_LIMIT:  well_known_limit = i_cfg_data[W_PORT-1:0];
                    default: ;
                endcase
            end

            if (i_pkt_mon.valid && i_pkt_mon.ready)
                reports_due.push_back(score_packet(i_pkt_mon.ip_protocol,
                    i_pkt_mon.tcp_flag_bits, i_pkt_mon.source_address,
                    i_pkt_mon.target_port, i_pkt_mon.arrival_us));

            if (i_rpt_mon.valid && i_rpt_mon.ready) begin
                if (reports_due.size() == 0) begin
                    $display("%0t: report mismatch, expected none, actual status %0d addr %0h",
                             $time, i_rpt_mon.status, i_rpt_mon.reported_address);
                    o_fail_count++;
                end else begin
                    want = reports_due.pop_front();
                    check_field("status", W_TIME'(want.status),
                                W_TIME'(i_rpt_mon.status));
                    check_field("reported_address", W_TIME'(want.addr),
                                W_TIME'(i_rpt_mon.reported_address));
                    check_field("reported_score", W_TIME'(want.score),
                                W_TIME'(i_rpt_mon.reported_score));
                    check_field("window_start_us", want.start, i_rpt_mon.window_start_us);
                end
            end
        end
        o_pending = reports_due.size();
    end

endmodule

### tb/sv/tb_port_scan_heat_tracker.sv
`timescale 1ns / 1ps

module tb_port_scan_heat_tracker import pst_pkg::*;;

    // Flag bytes used to build headers by hand
    localparam logic [W_FLAGS-1:0] F_FIN = W_FLAGS'(1) << FLAG_FIN;
    localparam logic [W_FLAGS-1:0] F_SYN = W_FLAGS'(1) << FLAG_SYN;
    localparam logic [W_FLAGS-1:0] F_ACK = W_FLAGS'(1) << FLAG_ACK;

    // Bucket that the saturation burst owns; the crowded pool buckets stay below it
    localparam logic [7:0] HOT_BUCKET = 8'hC3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [W_CFG_IDX-1:0]  cfg_idx;
    logic [W_CFG_DATA-1:0] cfg_data;
    logic                  rpt_ready = 1'b0;

    int                    fail_count;
    int                    pending;

    // Stimulus shaping state
    int                    n_sent = 0;
    int                    send_gap_pct = 0;
    int                    stall_pct = 0;
    int unsigned           cur_window;
    int unsigned           cur_limit;
    int unsigned           tick_max;
    logic [W_TIME-1:0]     clock_us;
    logic [W_ADDR-1:0]     pool [16];

    pst_in_if  pkt_if ();
    pst_out_if rpt_if ();

    assign rpt_if.ready = rpt_ready;

    port_scan_heat_tracker u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pkt      (pkt_if),
        .o_rpt      (rpt_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    heat_report_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pkt_mon    (pkt_if),
        .i_rpt_mon    (rpt_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Stall the report channel at the rate of the current idling phase.
    always @(posedge i_clk) begin
        rpt_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Build an address whose byte XOR lands in the given bucket.
    function automatic logic [W_ADDR-1:0] addr_in_bucket(input logic [7:0] bucket);
        logic [W_ADDR-1:0] upper;

        upper = $urandom;
        return {upper[31:8], bucket ^ upper[31:24] ^ upper[23:16] ^ upper[15:8]};
    endfunction

    // Pick a destination port: special ports, well-known ports, anything.
    function automatic logic [W_PORT-1:0] pick_port();
        int r;

        r = $urandom_range(0, 99);
        if (r < 25) begin
            case ($urandom_range(0, 3))
                0: return PORT_SPEC_A;
                1: return PORT_SPEC_B;
                2: return PORT_SPEC_C;
                default: return PORT_SPEC_D;
            endcase
        end
        if (r < 60 && cur_limit != 0)
            return W_PORT'($urandom_range(0, cur_limit - 1));
        return W_PORT'($urandom);
    endfunction

    // Offer one header, after a random idle gap that may be empty, and hold it until taken.
    task automatic send_header(
        input logic [W_PROTO-1:0] proto,
        input logic [W_FLAGS-1:0] flags,
        input logic [W_ADDR-1:0]  addr,
        input logic [W_PORT-1:0]  port,
        input logic [W_TIME-1:0]  stamp
    );
        // Rotate the idling phase every 30 items
        case ((n_sent / 30) % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 72; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 72; end
            default: begin send_gap_pct = 38; stall_pct = 38; end
        endcase
        while ($urandom_range(0, 99) < send_gap_pct) begin
            pkt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pkt_if.valid          <= 1'b1;
        pkt_if.ip_protocol    <= proto;
        pkt_if.tcp_flag_bits  <= flags;
        pkt_if.source_address <= addr;
        pkt_if.target_port    <= port;
        pkt_if.arrival_us     <= stamp;
        do @(posedge i_clk); while (pkt_if.ready !== 1'b1);
        n_sent++;
    endtask

    // Drop valid and wait until every report has come back.
    task automatic drain();
        pkt_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [W_CFG_IDX-1:0] idx, input int unsigned value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= W_CFG_DATA'(value);
        @(posedge i_clk);
    endtask

    // Write all six registers, then refresh the address pool for the phase.
    task automatic set_config(
        input int unsigned thr,
        input int unsigned win,
        input int unsigned spec,
        input int unsigned wk,
        input int unsigned other,
        input int unsigned limit
    );
        logic [7:0] b0;
        logic [7:0] b1;

        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_WGT_SPEC, spec);
        write_reg(CFG_WGT_WK, wk);
        write_reg(CFG_WGT_OTHER, other);
        write_reg(CFG_WK_LIMIT, limit);
        cfg_we     <= 1'b0;
        cur_window = win;
        cur_limit  = limit;
        tick_max   = win / 4 + 1;
        clock_us   = W_TIME'({$urandom, $urandom});

        // Crowd six sources into each of two buckets so both fill up
        b0 = 8'($urandom_range(0, 127));
        b1 = 8'($urandom_range(0, 127));
        for (int i = 0; i < 6; i++) begin
            pool[i]     = addr_in_bucket(b0);
            pool[i + 6] = addr_in_bucket(b1);
        end
        for (int i = 12; i < 16; i++)
            pool[i] = $urandom;
    endtask

    // Mostly plain SYNs from the pool; the rest is noise of any kind.
    task automatic run_random(input int count);
        logic [W_PROTO-1:0] proto;
        logic [W_FLAGS-1:0] flags;
        logic [W_ADDR-1:0]  addr;
        logic [W_TIME-1:0]  stamp;

        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 4)
                clock_us += W_TIME'(cur_window) + W_TIME'($urandom_range(1, 1000));
            else
                clock_us += W_TIME'($urandom_range(0, tick_max));
            stamp = clock_us;
            // Now and then arrive out of order
            if ($urandom_range(0, 99) < 4)
                stamp = clock_us - W_TIME'($urandom_range(0, 5000));

            addr = pool[$urandom_range(0, 15)];
            if ($urandom_range(0, 99) < 80) begin
                proto           = PROTO_TCP;
                flags           = W_FLAGS'($urandom);
                flags[FLAG_SYN] = 1'b1;
                flags[FLAG_ACK] = 1'b0;
                flags[FLAG_FIN] = 1'b0;
            end else begin
                proto = ($urandom_range(0, 1) == 1) ? PROTO_TCP : W_PROTO'($urandom);
                flags = W_FLAGS'($urandom);
                if ($urandom_range(0, 1) == 1)
                    addr = $urandom;
            end
            send_header(proto, flags, addr, pick_port(), stamp);
        end
    endtask

    initial begin
        logic [W_ADDR-1:0] addr_a;
        logic [W_ADDR-1:0] crowd [5];
        logic [W_ADDR-1:0] hot;

        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_idx               = CFG_THRESHOLD;
        cfg_data              = '0;
        pkt_if.valid          = 1'b0;
        pkt_if.ip_protocol    = '0;
        pkt_if.tcp_flag_bits  = '0;
        pkt_if.source_address = '0;
        pkt_if.target_port    = '0;
        pkt_if.arrival_us     = '0;
        cur_window            = RST_WINDOW;
        cur_limit             = RST_WK_LIMIT;
        tick_max              = RST_WINDOW / 4 + 1;
        clock_us              = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed headers at reset configuration.
        // Ignored: wrong protocol, SYN+ACK, SYN+FIN, no flags, all flags, FIN only.
        send_header(8'd0, F_SYN, 32'hFFFF_FFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
        send_header(8'hFF, F_SYN, 32'd0, 16'd0, 48'd0);
        send_header(PROTO_TCP, F_SYN | F_ACK, 32'd0, 16'd0, 48'd0);
        send_header(PROTO_TCP, F_SYN | F_FIN, 32'd0, 16'd0, 48'd0);
        send_header(PROTO_TCP, 8'h00, 32'd0, 16'd0, 48'd0);
        send_header(PROTO_TCP, 8'hFF, 32'd0, 16'd0, 48'd0);
        send_header(PROTO_TCP, F_FIN, 32'd0, 16'd0, 48'd0);

        // New source at address zero, then one source walked through every port class
        send_header(PROTO_TCP, F_SYN, 32'd0, 16'd0, 48'd0);
        addr_a = addr_in_bucket(8'd5);
        send_header(PROTO_TCP, F_SYN, addr_a, PORT_SPEC_A, 48'd100);
        send_header(PROTO_TCP, F_SYN, addr_a, PORT_SPEC_B, 48'd200);
        send_header(PROTO_TCP, F_SYN, addr_a, PORT_SPEC_C, 48'd300);  // reaches threshold
        send_header(PROTO_TCP, F_SYN, addr_a, PORT_SPEC_D, 48'd400);
        send_header(PROTO_TCP, F_SYN, addr_a, RST_WK_LIMIT - 16'd1, 48'd500);
        // SYN with RST and the top three flag bits set still counts as plain SYN
        send_header(PROTO_TCP, F_SYN | 8'hE4, addr_a, RST_WK_LIMIT, 48'd600);
        // Elapsed exactly the window, then one past it, then an earlier stamp
        send_header(PROTO_TCP, F_SYN, addr_a, 16'd70, 48'(RST_WINDOW) + 48'd300);
        send_header(PROTO_TCP, F_SYN, addr_a, 16'd70, 48'(RST_WINDOW) + 48'd301);
        send_header(PROTO_TCP, F_SYN, addr_a, 16'd70, 48'd50);

        // Fill one bucket, overflow it, then hit a stored way
        for (int i = 0; i < 5; i++)
            crowd[i] = addr_in_bucket(8'd9);
        for (int i = 0; i < 5; i++)
            send_header(PROTO_TCP, F_SYN, crowd[i], 16'd80, 48'd1000);
        send_header(PROTO_TCP, F_SYN, crowd[0], 16'd80, 48'd1001);

        // All-ones address folds into bucket zero beside address zero
        send_header(PROTO_TCP, F_SYN, 32'hFFFF_FFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
        send_header(PROTO_TCP, F_SYN, 32'd0, 16'd0, 48'd5);
        drain();

        // Low extremes: zero weights, zero window, nothing well known
        set_config(1, 0, 0, 0, 0, 0);
        run_random(100);
        drain();

        // High extremes; hammer one source until its score saturates
        set_config(SCORE_MAX, 999999, 255, 255, 200, 16'hFFFF);
        hot = addr_in_bucket(HOT_BUCKET);
        for (int i = 0; i < 300; i++) begin
            clock_us += W_TIME'($urandom_range(0, 20));
            send_header(PROTO_TCP, F_SYN, hot,
                        (i % 3 == 0) ? 16'hFFFF : W_PORT'($urandom_range(0, 65534)), clock_us);
        end
        run_random(50);
        drain();

        // Zero threshold: every hit inside the window reports a scan
        set_config(0, $urandom_range(1000, 20000), $urandom_range(0, 255),
                   $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 65535));
        run_random(100);
        drain();

        // Random mid-range settings
        for (int p = 0; p < 2; p++) begin
            set_config($urandom_range(10, 300), $urandom_range(100, 100000),
                       $urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 255), $urandom_range(0, 65535));
            run_random(90);
            drain();
        end

        // Let any stray report show up before the verdict
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_port_scan_heat_tracker: PASS");
        else
            $display("tb_port_scan_heat_tracker: FAIL");
        $finish;
    end

    // Stop a hung run.
    initial begin
        #2_000_000;
        $display("tb_port_scan_heat_tracker: FAIL");
        $finish;
    end

endmodule
